### rtl/qcp_pkg.sv
package qcp_pkg;

   // configuration register indexes
   localparam logic [1:0] REG_VERSION   = 2'd0;
   localparam logic [1:0] REG_CENTRES   = 2'd1;
   localparam logic [1:0] REG_ALN_COUNT = 2'd2;

   localparam int ALN_MAX = 7;

   localparam logic [7:0] HOME_RESET    = 8'd20;  // side - 1 for the smallest symbol
   localparam logic [7:0] SIDE_BASE     = 8'd21;
   localparam logic [7:0] FINDER_SPAN   = 8'd9;
   localparam logic [7:0] FINDER_EDGE   = 8'd8;
   localparam logic [7:0] VER_AREA      = 8'd11;
   localparam logic [7:0] TIMING_LINE   = 8'd6;
   localparam logic [5:0] VER_INFO_MIN  = 6'd6;
   localparam logic [7:0] END_COL       = 8'd1;
   localparam logic [7:0] POS_NONE      = 8'hFF;
   localparam logic [3:0] DATA_BITS     = 4'd8;

   typedef struct packed {
      logic [7:0] codeword;
      logic       final_codeword;
   } item_type;

   typedef struct packed {
      logic [5:0]                   version;
      logic [7:0]                   side;
      logic [ALN_MAX-1:0][7:0]      centres;
      logic [2:0]                   count;
   } cfg_type;

   typedef enum logic {
      WALK_IDLE,
      WALK_BUSY
   } walk_state_type;

   function automatic logic [2:0] remainder_len(input logic [5:0] v);
      logic [2:0] r;
      unique case (v)
         6'd1, 6'd2, 6'd3, 6'd4, 6'd5:                           r = 3'd7;
         6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19:        r = 3'd3;
         6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26:        r = 3'd4;
         6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33:        r = 3'd3;
         default:                                                r = 3'd0;
      endcase
      return r;
   endfunction

endpackage

### rtl/qcp_front.sv
module qcp_front
   import qcp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  logic [7:0] req_codeword,
   input  logic     req_final_codeword,
   output logic     q_valid,
   output item_type q_item,
   input  logic     q_pop
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{codeword: req_codeword, final_codeword: req_final_codeword};
      end
   end

endmodule

### rtl/qcp_reserved.sv
module qcp_reserved
   import qcp_pkg::*;
(
   input  logic [7:0] row,
   input  logic [7:0] col,
   input  cfg_type    cfg,
   output logic       reserved
);

   logic [ALN_MAX-1:0] row_hit;
   logic [ALN_MAX-1:0] col_hit;
   logic [2:0]         last_idx;
   logic               aln_hit;
   logic               fixed_hit;
   logic [8:0]         dr;
   logic [8:0]         dc;

   always_comb begin
      last_idx = cfg.count - 3'd1;
      row_hit  = '0;
      col_hit  = '0;
      for (int k = 0; k < ALN_MAX; k++) begin
         dr = {1'b0, row} - {1'b0, cfg.centres[k]};
         dc = {1'b0, col} - {1'b0, cfg.centres[k]};
         if (3'(k) < cfg.count) begin
            row_hit[k] = ($signed(dr) >= -9'sd2) && ($signed(dr) <= 9'sd2);
            col_hit[k] = ($signed(dc) >= -9'sd2) && ($signed(dc) <= 9'sd2);
         end
      end
      // corners shared with the finders carry no alignment pattern
      aln_hit = 1'b0;
      for (int a = 0; a < ALN_MAX; a++) begin
         for (int b = 0; b < ALN_MAX; b++) begin
            if (!((a == 0 && b == 0) || (a == 0 && 3'(b) == last_idx) ||
                  (3'(a) == last_idx && b == 0))) begin
               aln_hit = aln_hit | (row_hit[a] & col_hit[b]);
            end
         end
      end
   end

   always_comb begin
      fixed_hit = 1'b0;
      if (row < FINDER_SPAN && col < FINDER_SPAN) fixed_hit = 1'b1;
      if (row < FINDER_SPAN && col >= cfg.side - FINDER_EDGE) fixed_hit = 1'b1;
      if (row >= cfg.side - FINDER_EDGE && col < FINDER_SPAN) fixed_hit = 1'b1;
      if (row == TIMING_LINE || col == TIMING_LINE) fixed_hit = 1'b1;
      if (cfg.version >= VER_INFO_MIN) begin
         if (row < TIMING_LINE && col >= cfg.side - VER_AREA) fixed_hit = 1'b1;
         if (row >= cfg.side - VER_AREA && col < TIMING_LINE) fixed_hit = 1'b1;
      end
   end

   assign reserved = fixed_hit | aln_hit;

endmodule

### rtl/qcp_walker.sv
module qcp_walker
   import qcp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  item_type   q_item,
   output logic       q_pop,
   input  cfg_type    cfg,
   input  logic       rehome,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_module_row,
   output logic [7:0] rsp_module_col,
   output logic       rsp_dark,
   output logic       rsp_run_end,
   output logic       rsp_fill_mismatch
);

   walk_state_type state_ff, state_in;
   logic [7:0] row_ff, row_in;
   logic [7:0] col_ff, col_in;
   logic       up_ff, up_in;
   logic       left_step_ff, left_step_in;
   logic       exh_ff, exh_in;
   logic [3:0] left_ff, left_in;
   logic [7:0] cw_ff, cw_in;
   logic       fin_ff, fin_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_row_ff, rsp_row_in;
   logic [7:0] rsp_col_ff, rsp_col_in;
   logic       rsp_dark_ff, rsp_dark_in;
   logic       rsp_end_ff, rsp_end_in;
   logic       rsp_mm_ff, rsp_mm_in;

   logic       is_reserved;
   logic       go;
   logic       emit;
   logic       last;
   logic [7:0] home;
   logic [7:0] end_row;
   logic [7:0] row_adv;
   logic [7:0] col_adv;
   logic       up_adv;
   logic       at_edge;

   qcp_reserved u_reserved (
      .row      (row_ff),
      .col      (col_ff),
      .cfg      (cfg),
      .reserved (is_reserved)
   );

   assign home    = cfg.side - 8'd1;
   assign end_row = cfg.side - ((cfg.version >= VER_INFO_MIN) ? VER_AREA : FINDER_EDGE);
   assign go      = (state_ff == WALK_BUSY) && (!rsp_valid_ff || !rsp_stall);
   assign q_pop   = (state_ff == WALK_IDLE) && q_valid;

   // one zigzag step from the current cursor
   always_comb begin
      row_adv = row_ff;
      up_adv  = up_ff;
      at_edge = up_ff ? (row_ff == 8'd0) : (row_ff == home);
      if (!left_step_ff) begin
         if (at_edge) begin
            up_adv  = !up_ff;
            col_adv = col_ff - 8'd1;
         end else begin
            row_adv = up_ff ? row_ff - 8'd1 : row_ff + 8'd1;
            col_adv = col_ff + 8'd1;
         end
      end else begin
         col_adv = col_ff - 8'd1;
      end
      if (col_adv == TIMING_LINE) col_adv = col_adv - 8'd1;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         WALK_IDLE: if (q_valid) state_in = WALK_BUSY;
         WALK_BUSY: if (emit && last) state_in = WALK_IDLE;
         default:   state_in = WALK_IDLE;
      endcase
   end

   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      up_in        = up_ff;
      left_step_in = left_step_ff;
      exh_in       = exh_ff;
      left_in      = left_ff;
      cw_in        = cw_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_dark_in  = rsp_dark_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_mm_in    = rsp_mm_ff;
      emit         = 1'b0;
      last         = (left_ff == 4'd1);

      if (q_pop) begin
         cw_in   = q_item.codeword;
         fin_in  = q_item.final_codeword;
         left_in = DATA_BITS +
                   (q_item.final_codeword ? {1'b0, remainder_len(cfg.version)} : 4'd0);
      end

      if (rehome) begin
         row_in       = home;
         col_in       = home;
         up_in        = 1'b1;
         left_step_in = 1'b1;
         exh_in       = 1'b0;
      end

      if (go) begin
         if (exh_ff) begin
            emit = 1'b1;
         end else begin
            row_in       = row_adv;
            col_in       = col_adv;
            up_in        = up_adv;
            left_step_in = !left_step_ff;
            exh_in       = (col_adv == POS_NONE);
            emit         = !is_reserved;
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = exh_ff ? POS_NONE : row_ff;
         rsp_col_in   = exh_ff ? POS_NONE : col_ff;
         rsp_dark_in  = cw_ff[7];     // zeros shift in for remainder bits
         rsp_end_in   = last;
         rsp_mm_in    = last && fin_ff && (exh_in || row_in != end_row || col_in != END_COL);
         cw_in        = {cw_ff[6:0], 1'b0};
         left_in      = left_ff - 4'd1;
         if (last && fin_ff) begin
            row_in       = home;
            col_in       = home;
            up_in        = 1'b1;
            left_step_in = 1'b1;
            exh_in       = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= WALK_IDLE;
         row_ff       <= HOME_RESET;
         col_ff       <= HOME_RESET;
         up_ff        <= 1'b1;
         left_step_ff <= 1'b1;
         exh_ff       <= 1'b0;
         left_ff      <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         up_ff        <= up_in;
         left_step_ff <= left_step_in;
         exh_ff       <= exh_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cw_ff       <= cw_in;
      fin_ff      <= fin_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_dark_ff <= rsp_dark_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_mm_ff   <= rsp_mm_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_module_row    = rsp_row_ff;
   assign rsp_module_col    = rsp_col_ff;
   assign rsp_dark          = rsp_dark_ff;
   assign rsp_run_end       = rsp_end_ff;
   assign rsp_fill_mismatch = rsp_mm_ff;

`ifndef NO_ASSERTIONS
   a_idle_no_bits_left: assert property (@(posedge clock) disable iff (reset)
      state_ff == WALK_IDLE |-> left_ff == 4'd0)
      else $error("walker idle with bits still to place");

   a_mismatch_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_mm_ff |-> rsp_end_ff)
      else $error("fill mismatch flagged before end of run");

   a_none_pos_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_row_ff == POS_NONE) == (rsp_col_ff == POS_NONE)))
      else $error("only one coordinate marks an exhausted walk");

   a_load_from_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == WALK_BUSY && left_ff >= DATA_BITS)
      else $error("item load did not start a run");
`endif

endmodule

### rtl/qr_codeword_module_placer.sv
// QR codeword module placer.
// req_ channel: one codeword byte per transfer, req_final_codeword marks the
// last codeword of a symbol. rsp_ channel: one transfer per module write,
// giving row, column and bit value, MSB of the byte first. rsp_run_end marks
// the last write of an input item; on a final item the version's remainder
// bits (light) follow the eight data bits and rsp_fill_mismatch reports
// whether the walk missed its expected end position.
// csr_ port: index 0 version (also re-homes the cursor), 1 packed alignment
// centres, 2 alignment centre count. Write only while the block is idle.
// Timing: an item is loaded from the two-entry input queue, then the cursor
// takes one step per cycle while rsp_ is not stalled; each step lands on a free
// module or skips a reserved one. A run covers 8 data bits (plus up to 7
// remainder bits on a final item) and any skipped modules; the zigzag cursor
// step is the limiting loop. Results come from registered rsp_ outputs.
// Reset: empty queue, no pending result, version 0, cursor at bottom right.
// A stalled rsp_ holds its result and halts the walker; the queue keeps
// taking up to two further codewords before req_stall rises.
module qr_codeword_module_placer
   import qcp_pkg::*;
#(
   parameter int VERSION_COUNT = 40
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_codeword,
   input  logic        req_final_codeword,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_module_row,
   output logic [7:0]  rsp_module_col,
   output logic        rsp_dark,
   output logic        rsp_run_end,
   output logic        rsp_fill_mismatch,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [55:0] csr_wdata
);

   localparam int VER_LIM = (VERSION_COUNT - 1 > 39) ? 39 : VERSION_COUNT - 1;

   logic [5:0]  version_ff;
   logic [55:0] centres_ff;
   logic [2:0]  count_ff;
   logic        rehome_ff, rehome_in;
   logic [5:0]  version_sat;
   cfg_type     cfg;
   logic        q_valid;
   logic        q_pop;
   item_type    q_item;

   assign version_sat = (version_ff > 6'(VER_LIM)) ? 6'(VER_LIM) : version_ff;
   // re-home in the cycle after a version write, once the new side is in place
   assign rehome_in   = csr_we && (csr_index == REG_VERSION);

   always_comb begin
      cfg.version = version_sat;
      cfg.side    = SIDE_BASE + {version_sat, 2'b00};
      cfg.centres = centres_ff;
      cfg.count   = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= 6'd0;
         centres_ff <= 56'd0;
         count_ff   <= 3'd0;
         rehome_ff  <= 1'b0;
      end else begin
         rehome_ff <= rehome_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_VERSION:   version_ff <= csr_wdata[5:0];
               REG_CENTRES:   centres_ff <= csr_wdata;
               REG_ALN_COUNT: count_ff   <= csr_wdata[2:0];
               default:       ;
            endcase
         end
      end
   end

   qcp_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_codeword       (req_codeword),
      .req_final_codeword (req_final_codeword),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop)
   );

   qcp_walker u_walker (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .cfg               (cfg),
      .rehome            (rehome_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_module_row    (rsp_module_row),
      .rsp_module_col    (rsp_module_col),
      .rsp_dark          (rsp_dark),
      .rsp_run_end       (rsp_run_end),
      .rsp_fill_mismatch (rsp_fill_mismatch)
   );

endmodule

### sim/qcp_placement_checker.sv
module qcp_placement_checker
   import qcp_pkg::*;
#(
   parameter int VERSION_COUNT = 40
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_codeword,
   input  logic        req_final_codeword,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_module_row,
   input  logic [7:0]  rsp_module_col,
   input  logic        rsp_dark,
   input  logic        rsp_run_end,
   input  logic        rsp_fill_mismatch,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [55:0] csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          writes_seen
);

   typedef struct packed {
      logic [7:0] row;
      logic [7:0] col;
      logic       dark;
      logic       run_end;
      logic       fill_mismatch;
   } module_write_type;

   module_write_type expected_writes[$];

   logic [5:0]  version_reg;
   logic [55:0] centre_reg;
   logic [2:0]  centre_count;

   int   walk_row;
   int   walk_col;
   logic walk_up;
   logic walk_left_next;
   logic walk_spent;

   function automatic int active_version();
      int lim;
      int v;
      lim = VERSION_COUNT - 1;
      if (lim > 39) lim = 39;
      if (lim < 0) lim = 0;
      v = version_reg;
      return (v > lim) ? lim : v;
   endfunction

   function automatic int matrix_side();
      return 21 + 4 * active_version();
   endfunction

   function automatic int pad_bit_count(int v);
      if (v >= 1 && v <= 5) return 7;
      if (v >= 13 && v <= 19) return 3;
      if (v >= 20 && v <= 26) return 4;
      if (v >= 27 && v <= 33) return 3;
      return 0;
   endfunction

   function automatic void rehome_walk();
      walk_row       = matrix_side() - 1;
      walk_col       = matrix_side() - 1;
      walk_up        = 1'b1;
      walk_left_next = 1'b1;
      walk_spent     = 1'b0;
   endfunction

   // corner pairs that overlap the finders carry no alignment pattern
   function automatic logic in_alignment_area(int r, int c);
      int   n;
      int   a;
      int   b;
      int   dr;
      int   dc;
      logic hit;
      n   = centre_count;
      hit = 1'b0;
      for (a = 0; a < n; a++) begin
         for (b = 0; b < n; b++) begin
            if (!((a == 0 && b == 0) || (a == 0 && b == n - 1) || (a == n - 1 && b == 0))) begin
               dr = r - int'(centre_reg[8*a +: 8]);
               dc = c - int'(centre_reg[8*b +: 8]);
               if (dr >= -2 && dr <= 2 && dc >= -2 && dc <= 2) hit = 1'b1;
            end
         end
      end
      return hit;
   endfunction

   function automatic logic is_reserved(int r, int c);
      int s;
      s = matrix_side();
      if (r < 9 && c < 9) return 1'b1;
      if (r < 9 && c >= s - 8) return 1'b1;
      if (r >= s - 8 && c < 9) return 1'b1;
      if (r == 6 || c == 6) return 1'b1;
      if (active_version() >= 6) begin
         if (r < 6 && c >= s - 11) return 1'b1;
         if (r >= s - 11 && c < 6) return 1'b1;
      end
      return in_alignment_area(r, c);
   endfunction

   function automatic void step_walk();
      int s;
      s = matrix_side();
      if (!walk_left_next) begin
         if ((walk_up && walk_row == 0) || (!walk_up && walk_row == s - 1)) begin
            walk_up  = !walk_up;
            walk_col = walk_col - 2;
         end else begin
            walk_row = walk_row + (walk_up ? -1 : 1);
         end
         walk_col = walk_col + 1;
      end else begin
         walk_col = walk_col - 1;
      end
      walk_left_next = !walk_left_next;
      if (walk_col == 6) walk_col = 5;
      if (walk_col < 0) walk_spent = 1'b1;
   endfunction

   function automatic module_write_type next_module(logic value);
      module_write_type w;
      logic             found;
      w.row           = POS_NONE;
      w.col           = POS_NONE;
      w.dark          = value;
      w.run_end       = 1'b0;
      w.fill_mismatch = 1'b0;
      found           = 1'b0;
      while (!walk_spent && !found) begin
         found = !is_reserved(walk_row, walk_col);
         if (found) begin
            w.row = 8'(walk_row);
            w.col = 8'(walk_col);
         end
         step_walk();
      end
      return w;
   endfunction

   function automatic void predict_codeword(logic [7:0] cw, logic fin);
      module_write_type batch [15];
      int               n;
      int               k;
      int               rem;
      int               end_row;
      n = 0;
      for (k = 7; k >= 0; k--) begin
         batch[n] = next_module(cw[k]);
         n++;
      end
      if (fin) begin
         rem = pad_bit_count(active_version());
         for (k = 0; k < rem; k++) begin
            batch[n] = next_module(1'b0);
            n++;
         end
         end_row = matrix_side() - (active_version() >= 6 ? 11 : 8);
         batch[n-1].fill_mismatch = walk_spent || walk_row != end_row || walk_col != 1;
         rehome_walk();
      end
      batch[n-1].run_end = 1'b1;
      for (k = 0; k < n; k++) expected_writes.push_back(batch[k]);
   endfunction

   task automatic report_fault(string msg);
      $display("ERROR: %s", msg);
      fail_count++;
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want)
         report_fault($sformatf("module write %0d: %s is %0d, expected %0d",
                                writes_seen, name, got, want));
   endtask

   always @(posedge clock) begin
      module_write_type want;
      if (reset) begin
         version_reg  = '0;
         centre_reg   = '0;
         centre_count = '0;
         rehome_walk();
         expected_writes.delete();
         fail_count  = 0;
         writes_seen = 0;
         pending    <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_VERSION: begin
                  version_reg = csr_wdata[5:0];
                  rehome_walk();
               end
               REG_CENTRES:   centre_reg   = csr_wdata;
               REG_ALN_COUNT: centre_count = csr_wdata[2:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_codeword(req_codeword, req_final_codeword);
         if (rsp_valid && !rsp_stall) begin
            writes_seen++;
            if (expected_writes.size() == 0) begin
               report_fault($sformatf("module write %0d at row %0d col %0d with none expected",
                                      writes_seen, rsp_module_row, rsp_module_col));
            end else begin
               want = expected_writes.pop_front();
               check_field("row", rsp_module_row, want.row);
               check_field("col", rsp_module_col, want.col);
               check_field("dark", rsp_dark, want.dark);
               check_field("run_end", rsp_run_end, want.run_end);
               check_field("fill_mismatch", rsp_fill_mismatch, want.fill_mismatch);
            end
         end
         pending <= expected_writes.size();
      end
   end

endmodule

### sim/tb_qr_codeword_module_placer.sv
module tb_qr_codeword_module_placer
   import qcp_pkg::*;
();

   // index past the last register; writes to it must be ignored
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_LONG
   } stall_mode_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_codeword;
   logic        req_final_codeword;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_module_row;
   logic [7:0]  rsp_module_col;
   logic        rsp_dark;
   logic        rsp_run_end;
   logic        rsp_fill_mismatch;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [55:0] csr_wdata;

   int fail_count;
   int pending;
   int writes_seen;

   int burst_left  = 0;
   int items_sent  = 0;
   int symbol_runs = 0;
   int overruns    = 0;

   stall_mode_type stall_mode      = STALL_NONE;
   int             stall_mode_left = 0;
   int             stall_hold      = 0;

   qr_codeword_module_placer dut (.*);

   qcp_placement_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("timeout with %0d module writes outstanding", pending);
      $display("tb_qr_codeword_module_placer failed");
      $finish;
   end

   // receiver stall pattern, independent of the sender
   always @(posedge clock) begin
      if (stall_mode_left == 0) begin
         stall_mode      <= stall_mode_type'($urandom_range(0, 3));
         stall_mode_left <= $urandom_range(20, 150);
      end else begin
         stall_mode_left <= stall_mode_left - 1;
      end
      if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
         rsp_stall  <= 1'b1;
      end else begin
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 9) < 3);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
            default: begin
               if ($urandom_range(0, 11) == 0) stall_hold <= $urandom_range(5, 25);
               rsp_stall <= 1'b0;
            end
         endcase
      end
   end

   function automatic logic [55:0] standard_centres(int v);
      if (v == 0) return '0;
      return {40'd0, 8'(4 * v + 14), 8'd6};
   endfunction

   function automatic int symbol_capacity(int v);
      case (v)
         0:       return 26;
         1:       return 44;
         2:       return 70;
         default: return 100;
      endcase
   endfunction

   // valid stays high across back-to-back transfers inside a burst
   task automatic send_codeword(input logic [7:0] cw, input logic fin);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 10);
      end
      req_valid          <= 1'b1;
      req_codeword       <= cw;
      req_final_codeword <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      items_sent++;
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [55:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [55:0] version_word, input logic [55:0] centres,
                             input logic [55:0] count_word);
      write_reg(REG_VERSION, version_word);
      write_reg(REG_CENTRES, centres);
      write_reg(REG_ALN_COUNT, count_word);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      int          kind;
      int          n;
      int          k;
      int          ver;
      logic [63:0] rnd_a;
      logic [63:0] rnd_b;
      logic [63:0] rnd_c;
      logic        noisy;

      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_codeword       <= '0;
      req_final_codeword <= 1'b0;
      csr_we             <= 1'b0;
      csr_index          <= REG_VERSION;
      csr_wdata          <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset configuration, symbol ended early
      send_codeword(8'hFF, 1'b0);
      send_codeword(8'h00, 1'b0);
      send_codeword(8'h80, 1'b1);
      symbol_runs++;

      // largest symbol with all seven centres; stray register index ignored
      wait_idle();
      write_reg(REG_UNUSED, 56'({$urandom, $urandom}));
      set_config(56'd39, {8'd170, 8'd142, 8'd114, 8'd86, 8'd58, 8'd30, 8'd6}, 56'd7);
      send_codeword(8'h5A, 1'b0);
      send_codeword(8'hFF, 1'b1);
      symbol_runs++;

      // version field beyond the last version saturates
      wait_idle();
      set_config({56{1'b1}}, {56{1'b1}}, 56'd0);
      send_codeword(8'h01, 1'b1);
      symbol_runs++;

      // single centre: its only pair is dropped; max remainder bits
      wait_idle();
      set_config(56'd1, standard_centres(1), 56'd1);
      send_codeword(8'h3C, 1'b0);
      send_codeword(8'hC3, 1'b1);
      symbol_runs++;

      // version information areas present
      wait_idle();
      set_config(56'd6, {8'd38, 8'd22, 8'd6}, 56'd3);
      send_codeword(8'h96, 1'b0);
      send_codeword(8'h69, 1'b1);
      symbol_runs++;

      // alignment blocks tile the whole matrix: no free module, walk runs out
      wait_idle();
      set_config(56'd0, {8'd20, 8'd17, 8'd12, 8'd7, 8'd2}, 56'd5);
      send_codeword(8'hE7, 1'b0);
      send_codeword(8'h18, 1'b1);
      symbol_runs++;
      overruns++;

      while (items_sent < 430) begin
         wait_idle();
         kind  = $urandom_range(0, 9);
         noisy = (kind >= 8);
         if (!noisy) begin
            ver = $urandom_range(0, 3);
            set_config(56'(ver), standard_centres(ver), (ver == 0) ? 56'd0 : 56'd2);
            if (kind <= 5) begin
               n = symbol_capacity(ver);
            end else if (kind == 6) begin
               n = $urandom_range(1, symbol_capacity(ver) - 1);
            end else begin
               n = symbol_capacity(ver) + $urandom_range(1, 4);
               overruns++;
            end
         end else begin
            rnd_a = {$urandom, $urandom};
            rnd_b = {$urandom, $urandom};
            rnd_c = {$urandom, $urandom};
            ver   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 6);
            set_config({rnd_a[55:6], 6'(ver)}, rnd_b[55:0], rnd_c[55:0]);
            n = $urandom_range(1, 8);
         end
         for (k = 0; k < n; k++) begin
            if (noisy) send_codeword(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            else send_codeword(8'($urandom_range(0, 255)), k == n - 1);
         end
         symbol_runs++;
      end

      wait_idle();
      $display("covered %0d codewords over %0d symbol runs (%0d overrunning), %0d module writes",
               items_sent, symbol_runs, overruns, writes_seen);
      $display("mostly small versions plus the largest and saturated ones, alignment counts 0 to 7, stalls on both sides");
      if (fail_count == 0 && pending == 0) begin
         $display("tb_qr_codeword_module_placer passed");
      end else begin
         $display("tb_qr_codeword_module_placer failed");
      end
      $finish;
   end

endmodule
